[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL; they compile away for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
	else $error("assertion failed");
// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/fdr_pkg.sv]
`timescale 1ns / 1ps
package fdr_pkg;

	localparam int COS_W = 16;
	localparam int IDX_W = 16;
	localparam int A_W = 15;
	localparam int RAD_W = 60;
	localparam int ROOT_W = 30;
	localparam int NUM_W = 64;
	localparam int DEN_W = 48;
	localparam int Q_W = 16;
	localparam int SQRT_STAGES = 30;
	localparam int DIV_STAGES = 16;
	localparam int LANES = 2;

	localparam logic signed [COS_W-1:0] COS_MAX = 16'sd16384;
	localparam logic signed [COS_W-1:0] COS_MIN = -16'sd16384;
	localparam logic [Q_W-1:0] Q15_ONE = 16'd32768;
	localparam logic [28:0] Q28_ONE = 29'd268435456;
	localparam logic [IDX_W-1:0] INDEX_OUTSIDE_RST = 16'd4096;
	localparam logic [IDX_W-1:0] INDEX_INSIDE_RST = 16'd6144;

	// Lane numbers of the divider.
	localparam int LANE_PAR = 0;
	localparam int LANE_PERP = 1;

	typedef enum logic {
		REG_INDEX_OUTSIDE = 1'b0,
		REG_INDEX_INSIDE = 1'b1
	} reg_index_t;

	// Side data that rides along the square root pipe.
	typedef struct packed {
		logic tir;
		logic [A_W-1:0] a;
		logic [IDX_W-1:0] ei;
		logic [31:0] et2;
	} sq_side_t;

	// Side data that rides along the divider pipe.
	typedef struct packed {
		logic tir;
		logic [LANES-1:0] zero;
	} div_side_t;

endpackage

[hw/rtl/fdr_front.sv]
`timescale 1ns / 1ps
module fdr_front import fdr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic [COS_W-1:0] cos_incident,
	input logic [IDX_W-1:0] index_outside,
	input logic [IDX_W-1:0] index_inside,
	output logic out_valid,
	output sq_side_t out_side,
	output logic [RAD_W-1:0] out_rad
);

	logic signed [COS_W-1:0] cos_in, clamp, neg;
	logic [A_W-1:0] a;
	logic pos;

	// Clamp the cosine and take its magnitude.
	always_comb begin
		cos_in = $signed(cos_incident);
		if (cos_in > COS_MAX) begin
			clamp = COS_MAX;
		end else if (cos_in < COS_MIN) begin
			clamp = COS_MIN;
		end else begin
			clamp = cos_in;
		end
		neg = -clamp;
		a = clamp[COS_W-1] ? neg[A_W-1:0] : clamp[A_W-1:0];
		pos = !clamp[COS_W-1] && (clamp != '0);
	end

	logic v_s1, v_s2, v_s3, v_s4;
	logic [A_W-1:0] a_s1, a_s2, a_s3;
	logic [IDX_W-1:0] ei_s1, et_s1, ei_s2, ei_s3;
	logic [28:0] asq_s2;
	logic [31:0] ei2_s2, et2_s2, et2_s3;
	logic [RAD_W-1:0] lhs_s3, rhs_s3;
	logic [29:0] asq_full;
	logic [28:0] sin2;
	logic [60:0] lhs_full;

	always_comb begin
		asq_full = {15'b0, a_s1} * {15'b0, a_s1};
		sin2 = Q28_ONE - asq_s2;
		lhs_full = {29'b0, ei2_s2} * {32'b0, sin2};
	end

	// Advance valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Swap, square, form both sides of the Snell test, then compare.
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= a;
			ei_s1 <= pos ? index_inside : index_outside;
			et_s1 <= pos ? index_outside : index_inside;

			asq_s2 <= asq_full[28:0];
			ei2_s2 <= {16'b0, ei_s1} * {16'b0, ei_s1};
			et2_s2 <= {16'b0, et_s1} * {16'b0, et_s1};
			a_s2 <= a_s1;
			ei_s2 <= ei_s1;

			lhs_s3 <= lhs_full[RAD_W-1:0];
			rhs_s3 <= {et2_s2, 28'b0};
			a_s3 <= a_s2;
			ei_s3 <= ei_s2;
			et2_s3 <= et2_s2;

			out_side.tir <= (lhs_s3 >= rhs_s3);
			out_side.a <= a_s3;
			out_side.ei <= ei_s3;
			out_side.et2 <= et2_s3;
			out_rad <= (lhs_s3 >= rhs_s3) ? '0 : (rhs_s3 - lhs_s3);
		end
	end

	assign out_valid = v_s4;

endmodule

[hw/rtl/fdr_sqrt.sv]
`timescale 1ns / 1ps
module fdr_sqrt import fdr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input sq_side_t in_side,
	input logic [RAD_W-1:0] in_rad,
	output logic out_valid,
	output sq_side_t out_side,
	output logic [ROOT_W-1:0] out_root
);

	logic [SQRT_STAGES-1:0] v_sk;
	logic [RAD_W-1:0] rem_sk [SQRT_STAGES];
	logic [RAD_W-1:0] root_sk [SQRT_STAGES];
	sq_side_t side_sk [SQRT_STAGES];

	// One result bit per stage, most significant first.
	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		localparam logic [RAD_W:0] BIT = (RAD_W+1)'(1) << (2 * (SQRT_STAGES - 1 - k));
		logic v_in;
		logic [RAD_W-1:0] rem_in, root_in;
		sq_side_t side_in;
		logic [RAD_W:0] trial;

		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign rem_in = in_rad;
			assign root_in = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign v_in = v_sk[k-1];
			assign rem_in = rem_sk[k-1];
			assign root_in = root_sk[k-1];
			assign side_in = side_sk[k-1];
		end

		assign trial = {1'b0, root_in} + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[k] <= 1'b0;
			end else if (en) begin
				v_sk[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_sk[k] <= side_in;
				if ({1'b0, rem_in} >= trial) begin
					rem_sk[k] <= rem_in - trial[RAD_W-1:0];
					root_sk[k] <= (root_in >> 1) + BIT[RAD_W-1:0];
				end else begin
					rem_sk[k] <= rem_in;
					root_sk[k] <= root_in >> 1;
				end
			end
		end
	end

	assign out_valid = v_sk[SQRT_STAGES-1];
	assign out_side = side_sk[SQRT_STAGES-1];
	assign out_root = root_sk[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

[hw/rtl/fdr_div.sv]
`timescale 1ns / 1ps
module fdr_div import fdr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input div_side_t in_side,
	input logic [NUM_W-1:0] in_num [LANES],
	input logic [DEN_W-1:0] in_den [LANES],
	output logic out_valid,
	output div_side_t out_side,
	output logic [Q_W-1:0] out_quot [LANES]
);

	logic [DIV_STAGES-1:0] v_sk;
	div_side_t side_sk [DIV_STAGES];
	logic [NUM_W-1:0] rem_sk [DIV_STAGES][LANES];
	logic [DEN_W-1:0] den_sk [DIV_STAGES][LANES];
	logic [Q_W-1:0] quot_sk [DIV_STAGES][LANES];

	// Restoring division, one quotient bit per stage and lane.
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		localparam int SH = DIV_STAGES - 1 - k;
		logic v_in;
		div_side_t side_in;

		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign side_in = in_side;
		end else begin : g_next
			assign v_in = v_sk[k-1];
			assign side_in = side_sk[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sk[k] <= 1'b0;
			end else if (en) begin
				v_sk[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_sk[k] <= side_in;
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [NUM_W-1:0] rem_in, sub;
			logic [DEN_W-1:0] den_in;
			logic [Q_W-1:0] quot_in;

			if (k == 0) begin : g_first
				assign rem_in = in_num[l];
				assign den_in = in_den[l];
				assign quot_in = '0;
			end else begin : g_next
				assign rem_in = rem_sk[k-1][l];
				assign den_in = den_sk[k-1][l];
				assign quot_in = quot_sk[k-1][l];
			end

			assign sub = NUM_W'(den_in) << SH;

			always_ff @(posedge clk) begin
				if (en) begin
					den_sk[k][l] <= den_in;
					if (rem_in >= sub) begin
						rem_sk[k][l] <= rem_in - sub;
						quot_sk[k][l] <= {quot_in[Q_W-2:0], 1'b1};
					end else begin
						rem_sk[k][l] <= rem_in;
						quot_sk[k][l] <= {quot_in[Q_W-2:0], 1'b0};
					end
				end
			end
		end
	end

	assign out_valid = v_sk[DIV_STAGES-1];
	assign out_side = side_sk[DIV_STAGES-1];
	assign out_quot = quot_sk[DIV_STAGES-1];

endmodule

[hw/rtl/fresnel_dielectric_reflectance_top.sv]
`timescale 1ns / 1ps
// Unpolarized Fresnel reflectance between two dielectrics. Each s_tdata beat carries a
// signed Q2.14 cosine; each m_tdata beat returns the Q1.15 reflectance, with m_tuser set
// on total internal reflection. The block takes one beat per cycle and returns one per
// cycle while m_tready holds; a result passes through the 30-stage square root pipe and
// the 16-stage divider pipe. The whole pipe halts while a result waits on
// m_tready, so s_tready follows m_tready. Index registers are written through cfg_* and
// take effect for beats accepted afterwards; write them only while the pipe is empty.
`include "assert_macros.svh"
module fresnel_dielectric_reflectance_top import fdr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [15:0] s_tdata,    // [15:0] cos_incident
	output logic m_tvalid,
	input logic m_tready,
	output logic [15:0] m_tdata,   // [15:0] reflectance
	output logic [0:0] m_tuser,    // [0] total_reflection
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [15:0] cfg_data
);

	logic en;
	logic [IDX_W-1:0] index_outside_q, index_inside_q;

	// Stall everything while the output beat waits.
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;
	assign cfg_ready = 1'b1;

	// Hold the index registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_outside_q <= INDEX_OUTSIDE_RST;
			index_inside_q <= INDEX_INSIDE_RST;
		end else if (cfg_valid) begin
			unique case (reg_index_t'(cfg_index))
				REG_INDEX_OUTSIDE: index_outside_q <= cfg_data;
				REG_INDEX_INSIDE: index_inside_q <= cfg_data;
			endcase
		end
	end

	logic fr_valid;
	sq_side_t fr_side;
	logic [RAD_W-1:0] fr_rad;

	fdr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(s_tvalid),
		.cos_incident(s_tdata),
		.index_outside(index_outside_q),
		.index_inside(index_inside_q),
		.out_valid(fr_valid),
		.out_side(fr_side),
		.out_rad(fr_rad)
	);

	logic sq_valid;
	sq_side_t sq_side;
	logic [ROOT_W-1:0] sq_root;

	fdr_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(fr_valid),
		.in_side(fr_side),
		.in_rad(fr_rad),
		.out_valid(sq_valid),
		.out_side(sq_side),
		.out_root(sq_root)
	);

	// Products for both ratios.
	logic v_s1, v_s2, v_s3, v_s4;
	logic tir_s1, tir_s3;
	logic [46:0] pa_s1, pb_s1, qa_s1, qb_s1;
	logic [NUM_W-1:0] num_s2 [LANES];
	logic [DEN_W-1:0] den_s2 [LANES];
	div_side_t side_s2;
	logic [46:0] p_lane [LANES], q_lane [LANES], n_lane [LANES];
	logic [DEN_W-1:0] d_lane [LANES];
	logic [LANES-1:0] zero_lane;

	// Form |p - q| and p + q, then the rounded numerator.
	always_comb begin
		p_lane[LANE_PAR] = pa_s1;
		q_lane[LANE_PAR] = pb_s1;
		p_lane[LANE_PERP] = qa_s1;
		q_lane[LANE_PERP] = qb_s1;
		for (int l = 0; l < LANES; l++) begin
			n_lane[l] = (p_lane[l] >= q_lane[l]) ? (p_lane[l] - q_lane[l])
				: (q_lane[l] - p_lane[l]);
			d_lane[l] = {1'b0, p_lane[l]} + {1'b0, q_lane[l]};
			zero_lane[l] = (d_lane[l] == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s1 <= sq_side.tir;
			pa_s1 <= {15'b0, sq_side.et2} * {32'b0, sq_side.a};
			pb_s1 <= {1'b0, {30'b0, sq_side.ei} * {16'b0, sq_root}};
			qa_s1 <= {16'b0, {15'b0, sq_side.ei} * {16'b0, sq_side.a}};
			qb_s1 <= {17'b0, sq_root};

			side_s2.tir <= tir_s1;
			side_s2.zero <= zero_lane;
			for (int l = 0; l < LANES; l++) begin
				num_s2[l] <= {2'b0, n_lane[l], 15'b0} + {17'b0, d_lane[l][DEN_W-1:1]};
				den_s2[l] <= d_lane[l];
			end
		end
	end

	logic dv_valid;
	div_side_t dv_side;
	logic [Q_W-1:0] dv_quot [LANES];

	fdr_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(v_s2),
		.in_side(side_s2),
		.in_num(num_s2),
		.in_den(den_s2),
		.out_valid(dv_valid),
		.out_side(dv_side),
		.out_quot(dv_quot)
	);

	// Square both ratios, then average and saturate.
	logic [Q_W-1:0] r_lane [LANES];
	logic [30:0] sq_s3 [LANES];
	logic [31:0] sum;
	logic [15:0] mean;
	logic [15:0] refl_s4;
	logic tir_s4;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			r_lane[l] = dv_side.zero[l] ? Q15_ONE : dv_quot[l];
		end
		sum = {1'b0, sq_s3[LANE_PAR]} + {1'b0, sq_s3[LANE_PERP]} + 32'd32768;
		mean = sum[31:16];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s3 <= dv_side.tir;
			for (int l = 0; l < LANES; l++) begin
				sq_s3[l] <= 31'({16'b0, r_lane[l]} * {16'b0, r_lane[l]});
			end
			tir_s4 <= tir_s3;
			refl_s4 <= (tir_s3 || mean > Q15_ONE) ? Q15_ONE : mean;
		end
	end

	// Advance valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= sq_valid;
			v_s2 <= v_s1;
			v_s3 <= dv_valid;
			v_s4 <= v_s3;
		end
	end

	assign m_tvalid = v_s4;
	assign m_tdata = refl_s4;
	assign m_tuser = tir_s4;

	`ASSERT_IMPLY(a_tir_full, clk, arst_n, m_tvalid && m_tuser[0], m_tdata == Q15_ONE)
	`ASSERT_IMPLY(a_refl_range, clk, arst_n, m_tvalid, m_tdata <= Q15_ONE)

endmodule

[dv/fdr_checker.sv]
`timescale 1ns / 1ps
module fdr_checker import fdr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [15:0] s_tdata,
	input logic m_tvalid,
	input logic m_tready,
	input logic [15:0] m_tdata,
	input logic [0:0] m_tuser,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [15:0] cfg_data,
	output int fail_count,
	output int pending
);

	typedef struct packed {
		logic [15:0] refl;
		logic tir;
	} refl_result_t;

	logic [15:0] n_out;
	logic [15:0] n_in;
	refl_result_t refl_queue[$];

	// Integer square root, floor.
	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Rounded |p-q|/(p+q) in Q15; one on a zero sum.
	function automatic logic [63:0] amp_ratio(input logic [63:0] p, input logic [63:0] q);
		logic [63:0] n;
		logic [63:0] d;
		n = (p >= q) ? p - q : q - p;
		d = p + q;
		if (d == 0) return 64'd32768;
		return ((n << 15) + (d >> 1)) / d;
	endfunction

	function automatic refl_result_t predict_reflectance(input logic signed [15:0] cosv);
		int c;
		logic [63:0] a, ei, et, s2, lhs, rhs, w, et2, rp, rs, r;
		refl_result_t res;
		c = int'(cosv);
		if (c > 16384) c = 16384;
		if (c < -16384) c = -16384;
		a = 64'((c < 0) ? -c : c);
		ei = 64'(n_out);
		et = 64'(n_in);
		if (c > 0) begin
			ei = 64'(n_in);
			et = 64'(n_out);
		end
		s2 = (64'd1 << 28) - a * a;
		et2 = et * et;
		lhs = ei * ei * s2;
		rhs = et2 << 28;
		if (lhs >= rhs) begin
			res.refl = 16'd32768;
			res.tir = 1'b1;
			return res;
		end
		w = floor_sqrt(rhs - lhs);
		rp = amp_ratio(et2 * a, ei * w);
		rs = amp_ratio(ei * a, w);
		r = (rp * rp + rs * rs + (64'd1 << 15)) >> 16;
		if (r > 32768) r = 32768;
		res.refl = r[15:0];
		res.tir = 1'b0;
		return res;
	endfunction

	assign pending = refl_queue.size();

	// Track registers, queue predictions, compare each output beat.
	always @(posedge clk or negedge arst_n) begin
		refl_result_t exp_r;
		if (!arst_n) begin
			n_out <= INDEX_OUTSIDE_RST;
			n_in <= INDEX_INSIDE_RST;
			fail_count <= 0;
			refl_queue.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_INDEX_OUTSIDE) n_out <= cfg_data;
				else n_in <= cfg_data;
			end
			if (s_tvalid && s_tready)
				refl_queue.push_back(predict_reflectance(s_tdata));
			if (m_tvalid && m_tready) begin
				if (refl_queue.size() == 0) begin
					$display("%0t: unexpected beat refl=%0d tir=%0d", $time, m_tdata,
						m_tuser);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = refl_queue.pop_front();
					if (exp_r.refl !== m_tdata || exp_r.tir !== m_tuser[0]) begin
						$display("%0t: mismatch expected refl=%0d tir=%0d actual refl=%0d tir=%0d",
							$time, exp_r.refl, exp_r.tir, m_tdata, m_tuser);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

[dv/tb_fresnel_dielectric_reflectance_top.sv]
`timescale 1ns / 1ps
module tb_fresnel_dielectric_reflectance_top;
	import fdr_pkg::*;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [15:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [15:0] m_tdata;
	logic [0:0] m_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [0:0] cfg_index;
	logic [15:0] cfg_data;
	int fail_count;
	int pending;

	fresnel_dielectric_reflectance_top u_dut (.*);

	fdr_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

	// Random backpressure, with random gaps between ready cycles and often none.
	initial begin
		int gap;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
			repeat (gap) begin
				@(posedge clk);
				m_tready <= 0;
			end
			@(posedge clk);
			m_tready <= 1;
		end
	end

	task automatic write_index(input reg_index_t idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	task automatic send_cosine(input logic [15:0] cosv, input bit allow_gap);
		int gap;
		gap = allow_gap ? $urandom_range(0, 11) : 0;
		if (allow_gap && $urandom_range(0, 2) == 0) gap = 0;
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= cosv;
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid at the edge that took the last beat, then wait for every result.
	task automatic drain_pipe;
		s_tvalid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	// Mostly in-range cosines, some beyond one and full-width noise.
	function automatic logic [15:0] rand_cosine;
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return 16'(16'sd16384 + $urandom_range(0, 16383));
			2: return 16'(-16'sd16384 - $urandom_range(0, 16384));
			default: return 16'($signed(17'($urandom_range(0, 32768))) - 17'sd16384);
		endcase
	endfunction

	function automatic logic [15:0] rand_index;
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(1, 65535));
			1: return 16'($urandom_range(1, 64));
			2: return 16'(16'hFFFF - $urandom_range(0, 255));
			default: return 16'($urandom_range(4096, 12288));
		endcase
	endfunction

	initial begin
		logic [15:0] directed[$] = '{16'h0000, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000,
			16'h0001, 16'hFFFF, 16'h4001, 16'hBFFF, 16'h2000, 16'hE000, 16'h2D41,
			16'hD2BF, 16'h5555, 16'hAAAA};
		logic [15:0] idx_sets[6][2] = '{'{16'd4096, 16'd6144}, '{16'd6144, 16'd4096},
			'{16'd1, 16'd65535}, '{16'd65535, 16'd1}, '{16'd0, 16'd4096},
			'{16'd4096, 16'd0}};
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		cfg_valid = 0;
		cfg_index = REG_INDEX_OUTSIDE;
		cfg_data = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		// Directed sweep at reset indices and several extreme index pairs.
		foreach (idx_sets[k]) begin
			if (k != 0) begin
				write_index(REG_INDEX_OUTSIDE, idx_sets[k][0]);
				write_index(REG_INDEX_INSIDE, idx_sets[k][1]);
			end
			foreach (directed[i]) send_cosine(directed[i], k == 0);
			drain_pipe();
		end
		// Random phases with random indices.
		for (int p = 0; p < 12; p++) begin
			write_index(REG_INDEX_OUTSIDE, rand_index());
			write_index(REG_INDEX_INSIDE, rand_index());
			for (int i = 0; i < 150; i++) send_cosine(rand_cosine(), 1);
			drain_pipe();
		end
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
